// ===== rtl/swv_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding window variance package
// Shared constants, codes, state types and control structs.
// ----------------------------------------------------------------------------
package swv_pkg;

  // Default parameter values.
  localparam int WINDOW_DEPTH_DEF  = 1024;
  localparam int SAMPLE_BITS_DEF   = 24;
  localparam int FRACTION_BITS_DEF = 16;

  // Fixed port widths.
  localparam int SAMPLE_PORT_W = 24;
  localparam int STAT_W        = 62;
  localparam int STAT_SEL_W    = 2;
  localparam int STATUS_W      = 2;

  // Largest reportable statistic; larger results saturate to it.
  localparam logic [STAT_W-1:0] STAT_MAX = '1;

  // Item commands.
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // Statistic selection codes.
  localparam logic [STAT_SEL_W-1:0] SEL_SAMPLE_STDDEV = 2'd0;
  localparam logic [STAT_SEL_W-1:0] SEL_POP_STDDEV    = 2'd1;
  localparam logic [STAT_SEL_W-1:0] SEL_SAMPLE_VAR    = 2'd2;
  localparam logic [STAT_SEL_W-1:0] SEL_POP_VAR       = 2'd3;

  // Minimum window counts for a valid statistic.
  localparam int MIN_COUNT_SAMPLE = 2;
  localparam int MIN_COUNT_POP    = 1;

  typedef enum logic [2:0] {
    WS_IDLE,
    WS_SQUARE,
    WS_UPDATE,
    WS_START,
    WS_WAIT
  } win_state_t;

  typedef enum logic [2:0] {
    SU_IDLE,
    SU_MUL,
    SU_SUB,
    SU_DIV,
    SU_ROOT,
    SU_DONE
  } stat_state_t;

  // Request from the window controller to the statistic unit.
  typedef struct packed {
    logic start;
    logic population;
    logic variance;
  } stat_cmd_t;

  // Result control from the window controller to the output register.
  typedef struct packed {
    logic                load;
    logic                stat_valid;
    logic [STATUS_W-1:0] status;
  } win_res_t;

endpackage

// ===== rtl/swv_ring_ram.sv =====
// ----------------------------------------------------------------------------
// Sliding window sample store
// Simple dual-port synchronous RAM, one write and one read port, with
// registered read data.
// ----------------------------------------------------------------------------
module swv_ring_ram #(
  parameter int DEPTH  = swv_pkg::WINDOW_DEPTH_DEF,
  parameter int WIDTH  = swv_pkg::SAMPLE_BITS_DEF,
  parameter int ADDR_W = $clog2(swv_pkg::WINDOW_DEPTH_DEF)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/swv_stat_unit.sv =====
// ----------------------------------------------------------------------------
// Sliding window statistic unit
// Computes (n*sumsq - sum^2) scaled and divided by n*n or n*(n-1), with an
// optional integer square root, one bit per cycle.
// ----------------------------------------------------------------------------
module swv_stat_unit #(
  parameter int CNT_W         = 11,
  parameter int SUM_W         = 35,
  parameter int SSQ_W         = 58,
  parameter int FRACTION_BITS = swv_pkg::FRACTION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  swv_pkg::stat_cmd_t        cmd,
  input  logic [CNT_W-1:0]          count,
  input  logic signed [SUM_W-1:0]   sum,
  input  logic [SSQ_W-1:0]          sumsq,
  output logic                      ready,
  output logic [swv_pkg::STAT_W-1:0] value
);

  localparam int MAG_W  = SUM_W - 1;
  localparam int PROD_W = SSQ_W + CNT_W;
  localparam int Q_W    = 2 * CNT_W;
  localparam int DV_W   = PROD_W + 2 * FRACTION_BITS;
  localparam int RT_W   = (DV_W + 1) / 2;
  localparam int RAD_W  = 2 * RT_W;
  localparam int REM_W  = RT_W + 2;
  localparam int STEP_W = $clog2(DV_W + 1);
  localparam int EXT_W  = (DV_W > swv_pkg::STAT_W) ? DV_W : swv_pkg::STAT_W;

  swv_pkg::stat_state_t state, state_next;

  logic [STEP_W-1:0] step;
  logic              variance_q;
  logic [CNT_W-1:0]  n_sh;
  logic [MAG_W-1:0]  mag_sh;
  logic [PROD_W-1:0] ssq_mc;
  logic [PROD_W-1:0] mag_mc;
  logic [PROD_W-1:0] nsq_acc;
  logic [PROD_W-1:0] ssq_acc;
  logic [Q_W-1:0]    divisor;
  logic [DV_W-1:0]   dq;
  logic [Q_W-1:0]    rem_d;
  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem_r;
  logic [RT_W-1:0]   root;

  logic                    start_ok;
  logic [CNT_W-1:0]        count_b;
  logic signed [SUM_W-1:0] sum_abs;
  logic [PROD_W-1:0]       diff;
  logic [Q_W:0]            div_trial;
  logic                    div_bit;
  logic [DV_W-1:0]         dq_next;
  logic [REM_W-1:0]        rt_trial;
  logic [REM_W-1:0]        rt_sub;
  logic                    rt_bit;
  logic [RT_W-1:0]         root_next;
  logic [EXT_W-1:0]        dq_ext;

  assign start_ok = cmd.start && (state == swv_pkg::SU_IDLE || state == swv_pkg::SU_DONE);

  // Second factor of the divisor: n for population, n-1 for sample.
  assign count_b = cmd.population ? count : count - CNT_W'(1);
  assign sum_abs = sum[SUM_W-1] ? -sum : sum;

  assign diff = (nsq_acc >= ssq_acc) ? nsq_acc - ssq_acc : '0;

  // Restoring division step.
  assign div_trial = {rem_d, dq[DV_W-1]};
  assign div_bit   = (div_trial >= {1'b0, divisor});
  assign dq_next   = {dq[DV_W-2:0], div_bit};

  // Digit-by-digit square root step, two radicand bits per root bit.
  assign rt_trial  = {rem_r[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign rt_sub    = {root, 2'b01};
  assign rt_bit    = (rt_trial >= rt_sub);
  assign root_next = {root[RT_W-2:0], rt_bit};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swv_pkg::SU_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      swv_pkg::SU_IDLE, swv_pkg::SU_DONE: begin
        if (cmd.start) state_next = swv_pkg::SU_MUL;
      end
      swv_pkg::SU_MUL: begin
        if (step == '0) state_next = swv_pkg::SU_SUB;
      end
      swv_pkg::SU_SUB: begin
        state_next = (divisor == '0) ? swv_pkg::SU_DONE : swv_pkg::SU_DIV;
      end
      swv_pkg::SU_DIV: begin
        if (step == '0) state_next = variance_q ? swv_pkg::SU_DONE : swv_pkg::SU_ROOT;
      end
      swv_pkg::SU_ROOT: begin
        if (step == '0) state_next = swv_pkg::SU_DONE;
      end
      default: state_next = swv_pkg::SU_IDLE;
    endcase
  end

  always_comb begin
    ready = (state == swv_pkg::SU_DONE);
  end

  always_ff @(posedge clk) begin
    unique case (state)
      swv_pkg::SU_IDLE, swv_pkg::SU_DONE: begin
        if (start_ok) begin
          variance_q <= cmd.variance;
          divisor    <= Q_W'(count) * Q_W'(count_b);
          n_sh       <= count;
          mag_sh     <= sum_abs[MAG_W-1:0];
          mag_mc     <= PROD_W'(sum_abs[MAG_W-1:0]);
          ssq_mc     <= PROD_W'(sumsq);
          nsq_acc    <= '0;
          ssq_acc    <= '0;
          step       <= STEP_W'(MAG_W - 1);
        end
      end
      swv_pkg::SU_MUL: begin
        // Both products by shift and add, multiplier bits low first.
        if (n_sh[0]) nsq_acc <= nsq_acc + ssq_mc;
        if (mag_sh[0]) ssq_acc <= ssq_acc + mag_mc;
        n_sh   <= n_sh >> 1;
        mag_sh <= mag_sh >> 1;
        ssq_mc <= ssq_mc << 1;
        mag_mc <= mag_mc << 1;
        step   <= step - STEP_W'(1);
      end
      swv_pkg::SU_SUB: begin
        if (divisor == '0) begin
          dq <= '0;
        end else if (variance_q) begin
          dq <= DV_W'(diff) << FRACTION_BITS;
        end else begin
          dq <= DV_W'(diff) << (2 * FRACTION_BITS);
        end
        rem_d <= '0;
        step  <= STEP_W'(DV_W - 1);
      end
      swv_pkg::SU_DIV: begin
        if (div_bit) begin
          rem_d <= Q_W'(div_trial - {1'b0, divisor});
        end else begin
          rem_d <= div_trial[Q_W-1:0];
        end
        dq    <= dq_next;
        rad   <= RAD_W'(dq_next);
        rem_r <= '0;
        root  <= '0;
        step  <= (step == '0) ? STEP_W'(RT_W - 1) : step - STEP_W'(1);
      end
      swv_pkg::SU_ROOT: begin
        rem_r <= rt_bit ? rt_trial - rt_sub : rt_trial;
        root  <= root_next;
        rad   <= rad << 2;
        step  <= step - STEP_W'(1);
        if (step == '0) dq <= DV_W'(root_next);
      end
      default: begin
        step <= '0;
      end
    endcase
  end

  // Saturate the finished result to the output width.
  assign dq_ext = EXT_W'(dq);
  assign value  = (dq_ext > EXT_W'(swv_pkg::STAT_MAX)) ? swv_pkg::STAT_MAX
                                                       : dq_ext[swv_pkg::STAT_W-1:0];

  // A new computation must never be requested while one is in progress.
  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> (state == swv_pkg::SU_IDLE || state == swv_pkg::SU_DONE))
    else $error("statistic unit started while busy");

endmodule

// ===== rtl/swv_window.sv =====
// ----------------------------------------------------------------------------
// Sliding window controller
// Accepts add and remove beats, keeps the ring store and the running count,
// sum and sum of squares, and sequences the statistic unit.
// ----------------------------------------------------------------------------
module swv_window #(
  parameter int WINDOW_DEPTH = swv_pkg::WINDOW_DEPTH_DEF,
  parameter int SAMPLE_BITS  = swv_pkg::SAMPLE_BITS_DEF,
  parameter int IDX_W        = 10,
  parameter int CNT_W        = 11,
  parameter int SUM_W        = 35,
  parameter int SSQ_W        = 58
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              cmd,
  input  logic [swv_pkg::SAMPLE_PORT_W-1:0] sample,
  input  logic [swv_pkg::STAT_SEL_W-1:0]    statistic,
  input  logic                              slot_free,
  input  logic                              stat_ready,
  output swv_pkg::stat_cmd_t                scmd,
  output swv_pkg::win_res_t                 res,
  output logic [CNT_W-1:0]                  count,
  output logic signed [SUM_W-1:0]           sum,
  output logic [SSQ_W-1:0]                  sumsq
);

  localparam int SQ_W = 2 * SAMPLE_BITS - 1;

  swv_pkg::win_state_t state, state_next;

  logic [IDX_W-1:0]              oldest_idx;
  logic [IDX_W-1:0]              next_idx;
  logic                          cmd_reg;
  logic [swv_pkg::STATUS_W-1:0]  status_reg;
  logic [SAMPLE_BITS-1:0]        sample_reg;
  logic signed [SAMPLE_BITS-1:0] op_value;
  logic [SQ_W-1:0]               op_sq;

  logic                            accept;
  logic                            full;
  logic                            empty;
  logic [swv_pkg::STATUS_W-1:0]    status_next;
  logic [SAMPLE_BITS-1:0]          ram_rdata;
  logic signed [SAMPLE_BITS-1:0]   operand;
  logic signed [2*SAMPLE_BITS-1:0] op_prod;
  logic [SUM_W-1:0]                op_ext;
  logic                            population;
  logic                            variance;
  logic [CNT_W:0]                  occ_sum;
  logic [CNT_W:0]                  occ_wrap;

  assign accept = (state == swv_pkg::WS_IDLE) && in_valid;
  assign full   = (count == CNT_W'(WINDOW_DEPTH));
  assign empty  = (count == '0);

  always_comb begin
    if (cmd == swv_pkg::CMD_ADD) begin
      status_next = full ? swv_pkg::STATUS_FULL : swv_pkg::STATUS_OK;
    end else begin
      status_next = empty ? swv_pkg::STATUS_EMPTY : swv_pkg::STATUS_OK;
    end
  end

  // Writes land at the accepting edge; a remove reads the oldest entry at the
  // same edge, so its data is ready in the following cycle.
  swv_ring_ram #(
    .DEPTH  (WINDOW_DEPTH),
    .WIDTH  (SAMPLE_BITS),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (accept && cmd == swv_pkg::CMD_ADD && !full),
    .waddr (next_idx),
    .wdata (sample[SAMPLE_BITS-1:0]),
    .re    (accept && cmd == swv_pkg::CMD_REMOVE),
    .raddr (oldest_idx),
    .rdata (ram_rdata)
  );

  assign operand = (cmd_reg == swv_pkg::CMD_REMOVE) ? signed'(ram_rdata) : signed'(sample_reg);
  assign op_prod = operand * operand;
  assign op_ext  = {{(SUM_W - SAMPLE_BITS){op_value[SAMPLE_BITS-1]}}, op_value};

  assign population = (statistic == swv_pkg::SEL_POP_STDDEV) ||
                      (statistic == swv_pkg::SEL_POP_VAR);
  assign variance   = (statistic == swv_pkg::SEL_SAMPLE_VAR) ||
                      (statistic == swv_pkg::SEL_POP_VAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swv_pkg::WS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      swv_pkg::WS_IDLE: begin
        if (accept) begin
          state_next = (status_next == swv_pkg::STATUS_OK) ? swv_pkg::WS_SQUARE
                                                           : swv_pkg::WS_START;
        end
      end
      swv_pkg::WS_SQUARE: state_next = swv_pkg::WS_UPDATE;
      swv_pkg::WS_UPDATE: state_next = swv_pkg::WS_START;
      swv_pkg::WS_START:  state_next = swv_pkg::WS_WAIT;
      swv_pkg::WS_WAIT: begin
        if (stat_ready && slot_free) state_next = swv_pkg::WS_IDLE;
      end
      default: state_next = swv_pkg::WS_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = (state == swv_pkg::WS_IDLE);
    scmd.start      = (state == swv_pkg::WS_START);
    scmd.population = population;
    scmd.variance   = variance;
    res.load        = (state == swv_pkg::WS_WAIT) && stat_ready && slot_free;
    res.stat_valid  = population ? (count >= CNT_W'(swv_pkg::MIN_COUNT_POP))
                                 : (count >= CNT_W'(swv_pkg::MIN_COUNT_SAMPLE));
    res.status      = status_reg;
  end

  // Item capture and the squaring stage need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_reg    <= cmd;
      status_reg <= status_next;
      sample_reg <= sample[SAMPLE_BITS-1:0];
    end
    if (state == swv_pkg::WS_SQUARE) begin
      op_value <= operand;
      op_sq    <= op_prod[SQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_idx <= '0;
      next_idx   <= '0;
      count      <= '0;
      sum        <= '0;
      sumsq      <= '0;
    end else if (state == swv_pkg::WS_UPDATE) begin
      if (cmd_reg == swv_pkg::CMD_ADD) begin
        next_idx <= (next_idx == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : next_idx + IDX_W'(1);
        count    <= count + CNT_W'(1);
        sum      <= sum + signed'(op_ext);
        sumsq    <= sumsq + SSQ_W'(op_sq);
      end else begin
        oldest_idx <= (oldest_idx == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_idx + IDX_W'(1);
        count      <= count - CNT_W'(1);
        sum        <= sum - signed'(op_ext);
        sumsq      <= sumsq - SSQ_W'(op_sq);
      end
    end
  end

  // The write pointer always sits count entries past the read pointer.
  assign occ_sum  = (CNT_W + 1)'(oldest_idx) + (CNT_W + 1)'(count);
  assign occ_wrap = (occ_sum >= (CNT_W + 1)'(WINDOW_DEPTH)) ?
                    occ_sum - (CNT_W + 1)'(WINDOW_DEPTH) : occ_sum;

  a_ring_consistent: assert property (@(posedge clk) disable iff (rst)
    occ_wrap == (CNT_W + 1)'(next_idx))
    else $error("ring pointers disagree with the window count");

  a_error_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (accept && status_next != swv_pkg::STATUS_OK) |=> ($stable(count) && $stable(sum)))
    else $error("rejected beat changed the window");

endmodule

// ===== rtl/sliding_window_variance.sv =====
// ----------------------------------------------------------------------------
// Sliding window variance
// Windowed variance and standard deviation over signed samples, from a
// running count, sum and sum of squares kept next to a ring store.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                                         Direction
//   -------   ---------------------------------------------   ---------
//   input     in_valid, in_ready, cmd, sample                 in
//   output    out_valid, out_ready, stat_value, stat_valid,   out
//             window_count, status
//   config    cfg_we, cfg_wdata (statistic select)            in
//
// One beat is taken at a time. A beat passes the window controller's square,
// update and start states, then the statistic unit runs one bit per cycle: a
// shift-add multiply over the sum magnitude, a restoring divide over the
// scaled difference and, for the deviations, a square root. A beat below
// the minimum count skips the divide and the square root. An add to a full
// window or a remove from an empty one skips the square and update states.
// Reset clears the pointers, the count, both sums, the statistic select and
// the output valid; the ring store is not cleared, since only entries inside
// the window are ever used.
// A finished result sits in the output register, so the next input beat is
// taken while it waits; a further result is held inside until the output
// register is free, so an output stall delays it.
// ----------------------------------------------------------------------------
module sliding_window_variance #(
  parameter int WINDOW_DEPTH  = swv_pkg::WINDOW_DEPTH_DEF,
  parameter int SAMPLE_BITS   = swv_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = swv_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,

  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                cmd,
  input  logic [swv_pkg::SAMPLE_PORT_W-1:0]   sample,

  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [swv_pkg::STAT_W-1:0]          stat_value,
  output logic                                stat_valid,
  output logic [$clog2(WINDOW_DEPTH + 1)-1:0] window_count,
  output logic [swv_pkg::STATUS_W-1:0]        status,

  input  logic                                cfg_we,
  input  logic [swv_pkg::STAT_SEL_W-1:0]      cfg_wdata
);

  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  // The sum grows by the count bits; the sum of squares holds count times
  // the largest square, which is the most negative sample squared.
  localparam int SUM_W = SAMPLE_BITS + CNT_W;
  localparam int SSQ_W = 2 * SAMPLE_BITS - 1 + CNT_W;

  logic [swv_pkg::STAT_SEL_W-1:0] statistic;

  swv_pkg::stat_cmd_t        scmd;
  swv_pkg::win_res_t         res;
  logic [CNT_W-1:0]          count;
  logic signed [SUM_W-1:0]   sum;
  logic [SSQ_W-1:0]          sumsq;
  logic                      stat_ready;
  logic [swv_pkg::STAT_W-1:0] stat_result;
  logic                      slot_free;

  // Write the statistic select only while no beat is in flight; not enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      statistic <= swv_pkg::SEL_SAMPLE_STDDEV;
    end else if (cfg_we) begin
      statistic <= cfg_wdata;
    end
  end

  // The output register is free when empty or being drained this cycle.
  assign slot_free = !out_valid || out_ready;

  swv_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .IDX_W        (IDX_W),
    .CNT_W        (CNT_W),
    .SUM_W        (SUM_W),
    .SSQ_W        (SSQ_W)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .sample     (sample),
    .statistic  (statistic),
    .slot_free  (slot_free),
    .stat_ready (stat_ready),
    .scmd       (scmd),
    .res        (res),
    .count      (count),
    .sum        (sum),
    .sumsq      (sumsq)
  );

  swv_stat_unit #(
    .CNT_W         (CNT_W),
    .SUM_W         (SUM_W),
    .SSQ_W         (SSQ_W),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_stat (
    .clk   (clk),
    .rst   (rst),
    .cmd   (scmd),
    .count (count),
    .sum   (sum),
    .sumsq (sumsq),
    .ready (stat_ready),
    .value (stat_result)
  );

  // Output register. Below the minimum count the statistic reads zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      stat_value   <= res.stat_valid ? stat_result : '0;
      stat_valid   <= res.stat_valid;
      window_count <= count;
      status       <= res.status;
    end
  end

  // A result is never written over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res.load |-> (!out_valid || out_ready))
    else $error("result loaded into a full output register");

endmodule
